>>> rtl/core/rto_pkg.sv
// ----------------------------------------------------------------------------
// rto_pkg
// Shared constants and helpers for the rectangle/triangle overlap pipeline.
// ----------------------------------------------------------------------------
package rto_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int COORD_W       = 24;
	localparam int SIZE_W        = 23;
	localparam int TOL_W         = 24;
	localparam int CMP_W         = 56;
	localparam logic [TOL_W-1:0] AREA_TOL_RESET = 24'd655;

	typedef logic signed [CMP_W-1:0] cmp_t;

	// num/den lies in [0,1]; den assumed nonzero by caller
	function automatic logic ratio_in_unit(input cmp_t num, input cmp_t den);
		logic r;
		if (den > 0) begin
			r = (num >= 0) && (num <= den);
		end else begin
			r = (num <= 0) && (num >= den);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/rto_edge.sv
// ----------------------------------------------------------------------------
// rto_edge
// Triangle edge versus one axis-aligned rectangle side, three stages.
// ----------------------------------------------------------------------------
module rto_edge #(
	parameter bit VERT = 1'b0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] p0x,
	input  logic signed [23:0] p0y,
	input  logic signed [23:0] p1x,
	input  logic signed [23:0] p1y,
	input  logic signed [24:0] q0x,
	input  logic signed [24:0] q0y,
	input  logic signed [23:0] q,
	output logic               hit
);

	logic signed [24:0] pdx_s2, pdy_s2;
	logic signed [25:0] ox_s2, oy_s2;
	logic signed [23:0] q_s2;
	logic signed [50:0] m1_s3, m2_s3;
	logic signed [49:0] den_s3;
	logic               naf_s3;
	logic signed [25:0] dsel;
	logic               naf;

	always_ff @(posedge clk) begin
		if (en) begin
			pdx_s2 <= 25'(p1x) - 25'(p0x);
			pdy_s2 <= 25'(p1y) - 25'(p0y);
			ox_s2  <= 26'(p0x) - 26'(q0x);
			oy_s2  <= 26'(p0y) - 26'(q0y);
			q_s2   <= q;
		end
	end

	// side parameter reduces to a plain ratio once the side length cancels
	always_comb begin
		if (VERT) begin
			dsel = 26'(pdx_s2);
			naf  = rto_pkg::ratio_in_unit(-56'(ox_s2), 56'(pdx_s2));
		end else begin
			dsel = -26'(pdy_s2);
			naf  = rto_pkg::ratio_in_unit(56'(oy_s2), -56'(pdy_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s3  <= pdx_s2 * oy_s2;
			m2_s3  <= pdy_s2 * ox_s2;
			den_s3 <= q_s2 * dsel;
			naf_s3 <= naf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= naf_s3 && (den_s3 != '0) &&
				rto_pkg::ratio_in_unit(56'(m1_s3) - 56'(m2_s3), 56'(den_s3));
		end
	end

endmodule

>>> rtl/core/rto_corner.sv
// ----------------------------------------------------------------------------
// rto_corner
// Sum of the three doubled sub-areas around one rectangle corner.
// ----------------------------------------------------------------------------
module rto_corner (
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] ax,
	input  logic signed [23:0] ay,
	input  logic signed [23:0] bx,
	input  logic signed [23:0] by,
	input  logic signed [23:0] cx,
	input  logic signed [23:0] cy,
	input  logic signed [24:0] px,
	input  logic signed [24:0] py,
	output logic [54:0]        sum
);

	logic signed [23:0] vx [3];
	logic signed [23:0] vy [3];
	logic signed [25:0] dx_s2 [3];
	logic signed [25:0] dy_s2 [3];
	logic signed [51:0] p1_s3 [3];
	logic signed [51:0] p2_s3 [3];
	logic [52:0]        c_s4 [3];

	assign vx[0] = ax;
	assign vx[1] = bx;
	assign vx[2] = cx;
	assign vy[0] = ay;
	assign vy[1] = by;
	assign vy[2] = cy;

	for (genvar i = 0; i < 3; i++) begin : g_sub
		localparam int N = (i + 1) % 3;
		logic signed [52:0] t;

		assign t = 53'(p1_s3[i]) - 53'(p2_s3[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				dx_s2[i] <= 26'(vx[i]) - 26'(px);
				dy_s2[i] <= 26'(vy[i]) - 26'(py);
				p1_s3[i] <= dx_s2[i] * dy_s2[N];
				p2_s3[i] <= dx_s2[N] * dy_s2[i];
				c_s4[i]  <= t[52] ? 53'(-t) : 53'(t);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum <= 55'(c_s4[0]) + 55'(c_s4[1]) + 55'(c_s4[2]);
		end
	end

endmodule

>>> rtl/core/rect_triangle_overlap.sv
// ----------------------------------------------------------------------------
// rect_triangle_overlap
// Overlap test of an axis-aligned rectangle against a triangle.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one word is a rectangle (left, top,
//    width, height) and a triangle (three vertices), 8 fraction bits.
//  - Output channel (out_valid/out_ready): one word per input word, the
//    overlap flag, in input order.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): writes area_tolerance,
//    always ready; write only while the pipeline is empty.
//  - Throughput: one word per cycle when not stalled. The pipeline has seven
//    registers (input register, difference, multiply, edge/abs, area sum,
//    area difference, compare/output register).
//  - Stall: the whole pipeline advances only when the output register is
//    empty or being taken; in_ready follows that, so nothing is dropped.
//  - Reset: valid bits clear, tolerance returns to 655 (about 0.01).
// ----------------------------------------------------------------------------
module rect_triangle_overlap (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] rect_left,
	input  logic signed [23:0] rect_top,
	input  logic [22:0]        rect_width,
	input  logic [22:0]        rect_height,
	input  logic signed [23:0] tri_ax,
	input  logic signed [23:0] tri_ay,
	input  logic signed [23:0] tri_bx,
	input  logic signed [23:0] tri_by,
	input  logic signed [23:0] tri_cx,
	input  logic signed [23:0] tri_cy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               overlap,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        cfg_data
);

	localparam int PFB = 2 * rto_pkg::FRACTION_BITS;

	logic        adv;
	logic [23:0] tol_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, ov_q;

	// stage 1: captured word, far corner precomputed
	logic signed [23:0] l_s1, t_s1, ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [24:0] r_s1, b_s1;
	logic signed [23:0] w_s1, h_s1;

	assign adv       = !ov_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= rto_pkg::AREA_TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			ov_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s1  <= rect_left;
			t_s1  <= rect_top;
			r_s1  <= 25'(rect_left) + 25'({2'b00, rect_width});
			b_s1  <= 25'(rect_top) + 25'({2'b00, rect_height});
			w_s1  <= 24'({1'b0, rect_width});
			h_s1  <= 24'({1'b0, rect_height});
			ax_s1 <= tri_ax;
			ay_s1 <= tri_ay;
			bx_s1 <= tri_bx;
			by_s1 <= tri_by;
			cx_s1 <= tri_cx;
			cy_s1 <= tri_cy;
		end
	end

	// vertex strictly inside, carried to stage 4
	logic signed [23:0] vx [3];
	logic signed [23:0] vy [3];
	logic [2:0] pin;
	logic pin_s2, pin_s3, pin_s4;

	assign vx[0] = ax_s1;
	assign vx[1] = bx_s1;
	assign vx[2] = cx_s1;
	assign vy[0] = ay_s1;
	assign vy[1] = by_s1;
	assign vy[2] = cy_s1;

	for (genvar i = 0; i < 3; i++) begin : g_pin
		assign pin[i] = (vx[i] > l_s1) && (25'(vx[i]) < r_s1) &&
			(vy[i] > t_s1) && (25'(vy[i]) < b_s1);
	end

	// corners: TL, TR, BR, BL; side k runs corner k to corner k+1
	logic signed [24:0] kx [4];
	logic signed [24:0] ky [4];
	logic signed [23:0] kq [4];

	assign kx[0] = 25'(l_s1);
	assign ky[0] = 25'(t_s1);
	assign kx[1] = r_s1;
	assign ky[1] = 25'(t_s1);
	assign kx[2] = r_s1;
	assign ky[2] = b_s1;
	assign kx[3] = 25'(l_s1);
	assign ky[3] = b_s1;
	assign kq[0] = w_s1;
	assign kq[1] = h_s1;
	assign kq[2] = -w_s1;
	assign kq[3] = -h_s1;

	logic [11:0] ehit;

	for (genvar i = 0; i < 3; i++) begin : g_tri
		for (genvar k = 0; k < 4; k++) begin : g_side
			rto_edge #(
				.VERT((k % 2) == 1)
			) u_edge (
				.clk (clk),
				.en  (adv),
				.p0x (vx[i]),
				.p0y (vy[i]),
				.p1x (vx[(i + 1) % 3]),
				.p1y (vy[(i + 1) % 3]),
				.q0x (kx[k]),
				.q0y (ky[k]),
				.q   (kq[k]),
				.hit (ehit[i * 4 + k])
			);
		end
	end

	logic [54:0] csum_s5 [4];

	for (genvar k = 0; k < 4; k++) begin : g_corner
		rto_corner u_corner (
			.clk (clk),
			.en  (adv),
			.ax  (ax_s1),
			.ay  (ay_s1),
			.bx  (bx_s1),
			.by  (by_s1),
			.cx  (cx_s1),
			.cy  (cy_s1),
			.px  (kx[k]),
			.py  (ky[k]),
			.sum (csum_s5[k])
		);
	end

	// doubled triangle area
	logic signed [24:0] e1x_s2, e1y_s2, e2x_s2, e2y_s2;
	logic signed [49:0] w1_s3, w2_s3;
	logic signed [50:0] wd;
	logic [50:0]        whole_s4, whole_s5;
	logic               eh_s5, eh_s6;
	logic [55:0]        d_s6 [4];

	assign wd = 51'(w1_s3) - 51'(w2_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			e1x_s2   <= 25'(bx_s1) - 25'(ax_s1);
			e1y_s2   <= 25'(by_s1) - 25'(ay_s1);
			e2x_s2   <= 25'(cx_s1) - 25'(ax_s1);
			e2y_s2   <= 25'(cy_s1) - 25'(ay_s1);
			pin_s2   <= |pin;
			w1_s3    <= e1x_s2 * e2y_s2;
			w2_s3    <= e2x_s2 * e1y_s2;
			pin_s3   <= pin_s2;
			whole_s4 <= wd[50] ? 51'(-wd) : 51'(wd);
			pin_s4   <= pin_s3;
			whole_s5 <= whole_s4;
			eh_s5    <= pin_s4 || (|ehit);
			eh_s6    <= eh_s5;
		end
	end

	// area mismatch per corner
	for (genvar k = 0; k < 4; k++) begin : g_diff
		logic signed [55:0] sd;
		assign sd = $signed({1'b0, csum_s5[k]}) - $signed({5'b00000, whole_s5});
		always_ff @(posedge clk) begin
			if (adv) begin
				d_s6[k] <= sd[55] ? 56'(-sd) : 56'(sd);
			end
		end
	end

	// tolerance rescaled from 16 fraction bits to the product's
	logic [3:0] cin;

	for (genvar k = 0; k < 4; k++) begin : g_tol
		if (PFB >= 16) begin : g_up
			assign cin[k] = d_s6[k] < (56'(tol_q) << (PFB - 16));
		end else begin : g_dn
			assign cin[k] = (tol_q != '0) &&
				(d_s6[k] <= ((56'(tol_q) - 56'd1) >> (16 - PFB)));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			overlap <= eh_s6 || (|cin);
		end
	end

endmodule

>>> tb/sv/rect_triangle_overlap_checker.sv
// ----------------------------------------------------------------------------
// rect_triangle_overlap_checker
// Watches the input, output and tolerance channels of the overlap block,
// computes the expected overlap flag for each accepted word and compares.
// ----------------------------------------------------------------------------
module rect_triangle_overlap_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [23:0] rect_left,
	input  logic signed [23:0] rect_top,
	input  logic [22:0]        rect_width,
	input  logic [22:0]        rect_height,
	input  logic signed [23:0] tri_ax,
	input  logic signed [23:0] tri_ay,
	input  logic signed [23:0] tri_bx,
	input  logic signed [23:0] tri_by,
	input  logic signed [23:0] tri_cx,
	input  logic signed [23:0] tri_cy,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               overlap,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [23:0]        cfg_data,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [63:0] s64_t;

	logic [23:0] tol;
	logic        flag_q[$];

	function automatic logic in_unit(input s64_t num, input s64_t den);
		if (den > 0) begin
			return num >= 0 && num <= den;
		end
		return num <= 0 && num >= den;
	endfunction

	function automatic logic edges_meet(input s64_t p0x, input s64_t p0y, input s64_t p1x,
			input s64_t p1y, input s64_t q0x, input s64_t q0y, input s64_t q1x,
			input s64_t q1y);
		s64_t qdx, qdy, pdx, pdy, ox, oy, den, na, nb;
		qdx = q1x - q0x; qdy = q1y - q0y;
		pdx = p1x - p0x; pdy = p1y - p0y;
		ox = p0x - q0x; oy = p0y - q0y;
		den = qdy * pdx - qdx * pdy;
		na = qdx * oy - qdy * ox;
		nb = pdx * oy - pdy * ox;
		if (den == 0) begin
			return 1'b0;
		end
		return in_unit(na, den) && in_unit(nb, den);
	endfunction

	function automatic s64_t mag(input s64_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic s64_t twice_area(input s64_t ux, input s64_t uy, input s64_t vx,
			input s64_t vy, input s64_t px, input s64_t py);
		return mag((ux - px) * (vy - py) - (vx - px) * (uy - py));
	endfunction

	function automatic logic overlap_of(input s64_t l, input s64_t t, input s64_t w,
			input s64_t h, input s64_t ax, input s64_t ay, input s64_t bx,
			input s64_t by, input s64_t cx, input s64_t cy, input logic [23:0] tl);
		s64_t vx[3], vy[3], kx[4], ky[4], whole, sum, d;
		logic hit;
		int n;
		vx[0] = ax; vy[0] = ay; vx[1] = bx; vy[1] = by; vx[2] = cx; vy[2] = cy;
		kx[0] = l;     ky[0] = t;
		kx[1] = l + w; ky[1] = t;
		kx[2] = l + w; ky[2] = t + h;
		kx[3] = l;     ky[3] = t + h;
		hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			n = (i + 1) % 3;
			if (vx[i] > l && vx[i] < l + w && vy[i] > t && vy[i] < t + h) begin
				hit = 1'b1;
			end
			for (int k = 0; k < 4; k++) begin
				if (edges_meet(vx[i], vy[i], vx[n], vy[n], kx[k], ky[k],
						kx[(k + 1) % 4], ky[(k + 1) % 4])) begin
					hit = 1'b1;
				end
			end
		end
		whole = twice_area(vx[1], vy[1], vx[2], vy[2], vx[0], vy[0]);
		for (int k = 0; k < 4; k++) begin
			sum = twice_area(vx[0], vy[0], vx[1], vy[1], kx[k], ky[k]) +
				twice_area(vx[1], vy[1], vx[2], vy[2], kx[k], ky[k]) +
				twice_area(vx[2], vy[2], vx[0], vy[0], kx[k], ky[k]);
			d = mag(sum - whole);
			// 16 fraction bits on both sides, so a plain strict compare
			if (d < s64_t'(tl)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	assign pending = flag_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol <= rto_pkg::AREA_TOL_RESET;
			flag_q.delete();
		end else begin
			if (in_valid && in_ready) begin
				flag_q.push_back(overlap_of(rect_left, rect_top, rect_width, rect_height,
					tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy, tol));
			end
			if (out_valid && out_ready) begin
				if (flag_q.size() == 0) begin
					report_mismatch("overlap word with nothing expected");
				end else begin
					if (overlap !== flag_q[0]) begin
						report_mismatch($sformatf("overlap got %b want %b", overlap,
							flag_q[0]));
					end
					flag_q.pop_front();
				end
			end
			if (cfg_valid && cfg_ready) begin
				tol <= cfg_data;
			end
		end
	end
endmodule

>>> tb/sv/rect_triangle_overlap_test.sv
// ----------------------------------------------------------------------------
// rect_triangle_overlap_test
// Drives directed and random rectangle/triangle words with random gaps and
// output stalls, sweeps the area tolerance, and reports the verdict.
// ----------------------------------------------------------------------------
module rect_triangle_overlap_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 7;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [23:0] rect_left = '0, rect_top = '0;
	logic [22:0]        rect_width = '0, rect_height = '0;
	logic signed [23:0] tri_ax = '0, tri_ay = '0, tri_bx = '0;
	logic signed [23:0] tri_by = '0, tri_cx = '0, tri_cy = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               overlap;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [23:0]        cfg_data = '0;
	int                 errors, pending;

	// gap control: no idling while calm is set, long hold-off while hog is set
	bit calm = 1'b0;
	bit hog = 1'b0;
	bit stim_done = 1'b0;

	always #1 clk = ~clk;

	rect_triangle_overlap dut (.*);
	rect_triangle_overlap_checker chk (.*);

	// Receiver: random stalls, plus a long hold-off in each random phase, counted in cycles
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hog) begin
				out_ready <= 1'b0;
				for (hold = 0; hold < 60; hold++) begin
					@(negedge clk);
				end
				hog = 1'b0;
			end
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
		end
	end

	// Load one word and hold it until accepted; random idle before it.
	task automatic send_word(input logic [23:0] l, input logic [23:0] t,
			input logic [22:0] w, input logic [22:0] h, input logic [23:0] ax,
			input logic [23:0] ay, input logic [23:0] bx, input logic [23:0] by,
			input logic [23:0] cx, input logic [23:0] cy);
		while (!calm && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rect_left <= l; rect_top <= t; rect_width <= w; rect_height <= h;
		tri_ax <= ax; tri_ay <= ay; tri_bx <= bx; tri_by <= by;
		tri_cx <= cx; tri_cy <= cy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly small shapes near a shared origin so all outcomes occur;
	// some words at full range to toggle every bit.
	task automatic send_random;
		logic [23:0] c[6];
		logic [23:0] l, t;
		logic [22:0] w, h;
		int sp;
		if ($urandom_range(9) == 0) begin
			foreach (c[i]) c[i] = 24'($urandom);
			send_word(24'($urandom), 24'($urandom), 23'($urandom), 23'($urandom),
				c[0], c[1], c[2], c[3], c[4], c[5]);
		end else begin
			sp = 1 << $urandom_range(4, 14);
			l = 24'($signed($urandom_range(0, 2 * sp)) - sp);
			t = 24'($signed($urandom_range(0, 2 * sp)) - sp);
			w = 23'($urandom_range(0, sp));
			h = 23'($urandom_range(0, sp));
			foreach (c[i]) c[i] = 24'($signed($urandom_range(0, 4 * sp)) - 2 * sp);
			send_word(l, t, w, h, c[0], c[1], c[2], c[3], c[4], c[5]);
		end
	endtask

	// Tolerance write while idle: drain first, then let the pipe settle.
	task automatic set_tolerance(input logic [23:0] v);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [23:0] tols[5];
		tols = '{24'd0, 24'd1, 24'd655, 24'd70000, 24'hFFFFFF};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: default tolerance
		send_word(0, 0, 1024, 1024, 256, 256, 512, 256, 256, 512);     // vertex inside
		send_word(0, 0, 1024, 1024, -512, 512, 2048, 512, -512, 600);  // edge crosses
		send_word(100, 100, 10, 10, -4096, -4096, 4096, -4096, 0, 4096); // rect in tri
		send_word(0, 0, 256, 256, 1000, 1000, 2000, 1000, 1000, 2000); // apart
		send_word(0, 0, 256, 256, 256, 0, 512, 0, 512, 256);           // touch corner
		send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                       // all degenerate
		send_word(0, 0, 256, 256, -256, 0, 512, 0, 1024, 0);           // collinear edge
		send_word(24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 24'h7FFFFF,
			24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
		send_word(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'h800000,
			24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send_word(-5, -5, 3, 3, -1, -1, -1, -1, -1, -1);               // point triangle

		// random phases, one per tolerance setting
		for (int p = 0; p < 5; p++) begin
			set_tolerance(tols[p]);
			send_word(0, 0, 256, 256, -1, -1, -1, -1, -1, -1);
			send_word(0, 0, 256, 256, 0, -1, -1, 0, 0, 0);
			for (int n = 0; n < 240; n++) begin
				if (n == 40) begin
					calm = 1'b1;
				end
				if (n == 120) begin
					calm = 1'b0;
					hog = 1'b1;
				end
				send_random();
			end
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY * 4) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
